// ===== sv/tsd_pkg.sv =====
package tsd_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int SIZE_DIGITS = 12;
   localparam int OFF_W       = $clog2(BLOCK_BYTES);
   localparam int SIZE_W      = 36;
   localparam int SUM_W       = 17;
   localparam int KIND_W      = 3;
   localparam int TYPE_W      = 3;

   localparam int SIZE_AT = 124;
   localparam int CHK_AT  = 148;
   localparam int CHK_LEN = 8;
   localparam int TYPE_AT = 156;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_BODY   = 3'd1,
      PH_PAD    = 3'd2,
      PH_TRAIL  = 3'd4
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER = 3'd0,
      KIND_BODY   = 3'd1,
      KIND_PAD    = 3'd2,
      KIND_END    = 3'd3,
      KIND_TRAIL  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      kind_type          byte_kind;
      logic              header_done;
      logic [SIZE_W-1:0] entry_size;
      logic [TYPE_W-1:0] entry_type;
      logic [SUM_W-1:0]  header_sum;
      logic              entry_last;
      logic              archive_end;
   } result_type;

endpackage

// ===== sv/tsd_ifs.sv =====
interface tsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface tsd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [7:0]                 out_byte;
   logic [tsd_pkg::KIND_W-1:0] byte_kind;
   logic                       header_done;
   logic [tsd_pkg::SIZE_W-1:0] entry_size;
   logic [tsd_pkg::TYPE_W-1:0] entry_type;
   logic [tsd_pkg::SUM_W-1:0]  header_sum;
   logic                       entry_last;
   logic                       archive_end;

   modport source (output valid, output out_byte, output byte_kind, output header_done,
                   output entry_size, output entry_type, output header_sum,
                   output entry_last, output archive_end, input ready);
   modport sink (input valid, input out_byte, input byte_kind, input header_done,
                 input entry_size, input entry_type, input header_sum,
                 input entry_last, input archive_end, output ready);
endinterface

// ===== sv/tsd_core.sv =====
module tsd_core #(
   parameter int SIZE_DIGITS = tsd_pkg::SIZE_DIGITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   output tsd_pkg::result_type result
);
   import tsd_pkg::*;

   logic [OFF_W-1:0]  block_offset_ff, block_offset_in;
   phase_type         phase_ff, phase_in;
   logic [SIZE_W-1:0] size_accum_ff, size_accum_in;
   logic [SIZE_W-1:0] body_remaining_ff, body_remaining_in;
   logic [OFF_W-1:0]  pad_remaining_ff, pad_remaining_in;
   logic [SUM_W-1:0]  sum_accum_ff, sum_accum_in;
   logic [TYPE_W-1:0] type_value_ff, type_value_in;
   logic              name_empty_ff, name_empty_in;

   logic              first, last, is_octal, in_size, in_chk;
   logic [7:0]        diff;
   logic [TYPE_W-1:0] digit;
   logic [SIZE_W-1:0] size_base, body_dec;
   logic [SUM_W-1:0]  sum_base;
   logic [TYPE_W-1:0] type_base;
   logic [OFF_W-1:0]  pad_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_offset_ff   <= '0;
         phase_ff          <= PH_HEADER;
         size_accum_ff     <= '0;
         body_remaining_ff <= '0;
         pad_remaining_ff  <= '0;
         sum_accum_ff      <= '0;
         type_value_ff     <= '0;
         name_empty_ff     <= 1'b0;
      end else if (take) begin
         block_offset_ff   <= block_offset_in;
         phase_ff          <= phase_in;
         size_accum_ff     <= size_accum_in;
         body_remaining_ff <= body_remaining_in;
         pad_remaining_ff  <= pad_remaining_in;
         sum_accum_ff      <= sum_accum_in;
         type_value_ff     <= type_value_in;
         name_empty_ff     <= name_empty_in;
      end
   end

   always_comb begin
      first    = (block_offset_ff == '0);
      last     = (block_offset_ff == OFF_W'(BLOCK_BYTES - 1));
      is_octal = (data_byte inside {[CHAR_ZERO:CHAR_SEVEN]});
      in_size  = (block_offset_ff >= OFF_W'(SIZE_AT))
                 && (block_offset_ff < OFF_W'(SIZE_AT + SIZE_DIGITS));
      in_chk   = (block_offset_ff >= OFF_W'(CHK_AT))
                 && (block_offset_ff < OFF_W'(CHK_AT + CHK_LEN));
      diff     = data_byte - CHAR_ZERO;
      digit    = diff[TYPE_W-1:0];
      size_base = first ? '0 : size_accum_ff;
      sum_base  = first ? '0 : sum_accum_ff;
      type_base = first ? '0 : type_value_ff;
      body_dec  = body_remaining_ff - SIZE_W'(1);
      pad_dec   = pad_remaining_ff - OFF_W'(1);

      block_offset_in   = block_offset_ff;
      phase_in          = phase_ff;
      size_accum_in     = size_accum_ff;
      body_remaining_in = body_remaining_ff;
      pad_remaining_in  = pad_remaining_ff;
      sum_accum_in      = sum_accum_ff;
      type_value_in     = type_value_ff;
      name_empty_in     = name_empty_ff;

      result             = '0;
      result.out_byte    = data_byte;
      result.byte_kind   = KIND_TRAIL;

      case (phase_ff)
         PH_HEADER: begin
            name_empty_in = first ? (data_byte == 8'h00) : name_empty_ff;
            size_accum_in = (in_size && is_octal)
                            ? {size_base[SIZE_W-4:0], digit} : size_base;
            type_value_in = (block_offset_ff == OFF_W'(TYPE_AT))
                            ? (is_octal ? digit : '0) : type_base;
            sum_accum_in  = sum_base + SUM_W'(in_chk ? CHAR_SPACE : data_byte);
            result.byte_kind = name_empty_in ? KIND_END : KIND_HEADER;
            if (last) begin
               block_offset_in = '0;
               if (name_empty_in) begin
                  result.archive_end = 1'b1;
                  phase_in           = PH_TRAIL;
               end else begin
                  result.header_done = 1'b1;
                  result.entry_size  = size_accum_in;
                  result.entry_type  = type_value_in;
                  result.header_sum  = sum_accum_in;
                  if (size_accum_in == '0) begin
                     result.entry_last = 1'b1;
                  end else begin
                     body_remaining_in = size_accum_in;
                     pad_remaining_in  = OFF_W'(0) - size_accum_in[OFF_W-1:0];
                     phase_in          = PH_BODY;
                  end
               end
            end else begin
               block_offset_in = block_offset_ff + OFF_W'(1);
            end
         end
         PH_BODY: begin
            result.byte_kind  = KIND_BODY;
            body_remaining_in = body_dec;
            if (body_dec == '0) begin
               if (pad_remaining_ff != '0) begin
                  phase_in = PH_PAD;
               end else begin
                  result.entry_last = 1'b1;
                  phase_in          = PH_HEADER;
               end
            end
         end
         PH_PAD: begin
            result.byte_kind = KIND_PAD;
            pad_remaining_in = pad_dec;
            if (pad_dec == '0) begin
               result.entry_last = 1'b1;
               phase_in          = PH_HEADER;
            end
         end
         default: begin
            result.byte_kind   = KIND_TRAIL;
            result.archive_end = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/tsd_out_reg.sv =====
module tsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tsd_pkg::result_type result,
   output logic                can_load,
   tsd_rsp_if.source           rsp_chan
);
   import tsd_pkg::*;

   logic       rsp_valid_ff;
   result_type result_ff;

   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (can_load) begin
         rsp_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = result_ff.out_byte;
   assign rsp_chan.byte_kind   = result_ff.byte_kind;
   assign rsp_chan.header_done = result_ff.header_done;
   assign rsp_chan.entry_size  = result_ff.entry_size;
   assign rsp_chan.entry_type  = result_ff.entry_type;
   assign rsp_chan.header_sum  = result_ff.header_sum;
   assign rsp_chan.entry_last  = result_ff.entry_last;
   assign rsp_chan.archive_end = result_ff.archive_end;

endmodule

// ===== sv/tar_stream_deframer.sv =====
// Splits a tar archive, one byte per transfer, into header, body, padding,
// end marker and trailing bytes; every byte comes back out with its kind on
// the next cycle. The last byte of each 512-byte header carries the parsed
// octal size, the type digit and the header sum with the checksum field
// read as spaces; the checksum itself is left for software to compare. A
// header whose first byte is zero ends the archive and all later bytes are
// trailing until reset. One byte is taken every cycle, set by the single
// result register: input stalls only while that register holds a result
// that the sink has not taken.
module tar_stream_deframer #(
   parameter int SIZE_DIGITS = tsd_pkg::SIZE_DIGITS
) (
   input logic       clock,
   input logic       reset,
   tsd_req_if.sink   req_chan,
   tsd_rsp_if.source rsp_chan
);
   import tsd_pkg::*;

   logic       take;
   logic       can_load;
   result_type result;

   assign req_chan.ready = can_load;
   assign take           = req_chan.valid && can_load;

   tsd_core #(
      .SIZE_DIGITS (SIZE_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .result    (result)
   );

   tsd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !(req_chan.valid && req_chan.ready))
      else $error("transfer accepted while result is stalled");

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> rsp_chan.valid)
      else $error("accepted byte produced no result");

   a_header_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.header_done
      |-> rsp_chan.byte_kind == KIND_HEADER && !rsp_chan.archive_end)
      else $error("header_done outside a header block");

   a_end_no_entry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.archive_end |-> !rsp_chan.entry_last
      && (rsp_chan.byte_kind == KIND_END || rsp_chan.byte_kind == KIND_TRAIL))
      else $error("archive_end on an entry byte");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import tsd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RAND_BYTES  = 1300;
   localparam int SIZE_LEN    = 12;

   typedef enum logic [1:0] {
      FILL_ZERO,
      FILL_ONES,
      FILL_RAND
   } fill_type;

   typedef struct packed {
      logic [7:0]        name0;
      logic [95:0]       size_txt;
      logic [7:0]        type_ch;
      fill_type          fill;
      logic              typed;
      logic [SIZE_W-1:0] t_size;
      logic [TYPE_W-1:0] t_type;
      logic [SUM_W-1:0]  t_sum;
   } entry_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsd_req_if req_chan ();
   tsd_rsp_if rsp_chan ();

   tar_stream_deframer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   entry_row dir_rows [9] = '{
      '{8'h61, "000000000000", "0", FILL_ZERO, 1'b1, 36'd0, 3'd0, 17'd977},
      '{8'hFF, {12{8'hFF}}, 8'hFF, FILL_ONES, 1'b1, 36'd0, 3'd0, 17'd128776},
      '{8'h62, "000000001000", "5", FILL_ZERO, 1'b1, 36'd512, 3'd5, 17'd984},
      '{8'h63, "000000001001", "7", FILL_ZERO, 1'b1, 36'd513, 3'd7, 17'd988},
      '{8'h64, 96'h38_20_31_39_37_2F_33_00_78_FF_20_00, "x", FILL_ZERO, 1'b1,
        36'd123, 3'd0, 17'd1230},
      '{8'h65, "000000000001", 8'hFF, FILL_ZERO, 1'b1, 36'd1, 3'd0, 17'd1189},
      '{8'h66, "000000017777", "2", FILL_RAND, 1'b0, 36'd0, 3'd0, 17'd0},
      '{8'h01, "000000000777", "1", FILL_RAND, 1'b0, 36'd0, 3'd0, 17'd0},
      '{8'h80, "00000000010 ", "8", FILL_RAND, 1'b0, 36'd0, 3'd0, 17'd0}
   };

   logic [OFF_W-1:0]  hdr_off;
   phase_type         stage;
   logic [SIZE_W-1:0] size_acc;
   logic [SIZE_W-1:0] body_left;
   logic [OFF_W-1:0]  pad_left;
   logic [SUM_W-1:0]  sum_acc;
   logic [TYPE_W-1:0] type_dig;
   logic              end_block;

   result_type deframed_q [$];

   bit                typed_hdr = 1'b0;
   logic [SIZE_W-1:0] typed_size;
   logic [TYPE_W-1:0] typed_type;
   logic [SUM_W-1:0]  typed_sum;

   bit calm = 1'b0;
   int bytes_sent = 0;
   int bad_fields = 0;
   int quiet_cycles = 0;

   task automatic deframe_byte(input logic [7:0] b, output result_type r);
      logic octal;
      octal = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
      r = '0;
      r.out_byte = b;
      case (stage)
         PH_HEADER: begin
            if (hdr_off == 0) begin
               size_acc  = '0;
               sum_acc   = '0;
               type_dig  = '0;
               end_block = (b == 8'h00);
            end
            if (hdr_off >= SIZE_AT && hdr_off < SIZE_AT + SIZE_DIGITS && octal)
               size_acc = (size_acc << 3) + SIZE_W'(b - CHAR_ZERO);
            if (hdr_off == TYPE_AT)
               type_dig = octal ? TYPE_W'(b - CHAR_ZERO) : '0;
            if (hdr_off >= CHK_AT && hdr_off < CHK_AT + CHK_LEN)
               sum_acc = sum_acc + CHAR_SPACE;
            else
               sum_acc = sum_acc + b;
            r.byte_kind = end_block ? KIND_END : KIND_HEADER;
            if (hdr_off == BLOCK_BYTES - 1) begin
               hdr_off = '0;
               if (end_block) begin
                  r.archive_end = 1'b1;
                  stage = PH_TRAIL;
               end else begin
                  r.header_done = 1'b1;
                  r.entry_size  = size_acc;
                  r.entry_type  = type_dig;
                  r.header_sum  = sum_acc;
                  if (size_acc == 0) begin
                     r.entry_last = 1'b1;
                  end else begin
                     body_left = size_acc;
                     pad_left  = OFF_W'(0) - size_acc[OFF_W-1:0];
                     stage     = PH_BODY;
                  end
               end
            end else begin
               hdr_off = hdr_off + 1'b1;
            end
         end
         PH_BODY: begin
            r.byte_kind = KIND_BODY;
            body_left = body_left - 1'b1;
            if (body_left == 0) begin
               if (pad_left != 0) begin
                  stage = PH_PAD;
               end else begin
                  r.entry_last = 1'b1;
                  stage = PH_HEADER;
               end
            end
         end
         PH_PAD: begin
            r.byte_kind = KIND_PAD;
            pad_left = pad_left - 1'b1;
            if (pad_left == 0) begin
               r.entry_last = 1'b1;
               stage = PH_HEADER;
            end
         end
         default: begin
            r.byte_kind   = KIND_TRAIL;
            r.archive_end = 1'b1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                              input logic [SIZE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin : xfer_mon
      result_type want;
      if (reset) begin
         hdr_off   = '0;
         stage     = PH_HEADER;
         size_acc  = '0;
         body_left = '0;
         pad_left  = '0;
         sum_acc   = '0;
         type_dig  = '0;
         end_block = 1'b0;
         deframed_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            deframe_byte(req_chan.data_byte, want);
            if (typed_hdr) begin
               want.header_done = 1'b1;
               want.entry_size  = typed_size;
               want.entry_type  = typed_type;
               want.header_sum  = typed_sum;
            end
            deframed_q.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (deframed_q.size() == 0) begin
               $error("result transfer with nothing outstanding, out_byte %0h",
                      rsp_chan.out_byte);
               bad_fields++;
            end else begin
               want = deframed_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_chan.out_byte);
               check_field("byte_kind", want.byte_kind, rsp_chan.byte_kind);
               check_field("header_done", want.header_done, rsp_chan.header_done);
               check_field("entry_size", want.entry_size, rsp_chan.entry_size);
               check_field("entry_type", want.entry_type, rsp_chan.entry_type);
               check_field("header_sum", want.header_sum, rsp_chan.header_sum);
               check_field("entry_last", want.entry_last, rsp_chan.entry_last);
               check_field("archive_end", want.archive_end, rsp_chan.archive_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 35);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < 35) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] non_octal();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_SEVEN);
      return b;
   endfunction

   function automatic logic [95:0] octal_text(input int unsigned value);
      logic [95:0] txt;
      logic [2:0]  dig;
      bit          lead;
      lead = 1'b1;
      for (int i = 0; i < SIZE_LEN; i++) begin
         dig  = 3'(value >> (3 * (SIZE_LEN - 1 - i)));
         lead = lead && (dig == 0);
         if (lead && $urandom_range(0, 3) == 0)
            txt[8*(SIZE_LEN-1-i) +: 8] = non_octal();
         else
            txt[8*(SIZE_LEN-1-i) +: 8] = CHAR_ZERO + dig;
      end
      return txt;
   endfunction

   task automatic emit_entry(input entry_row row);
      logic [7:0] b;
      for (int off = 0; off < BLOCK_BYTES; off++) begin
         case (row.fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom_range(0, 255));
         endcase
         if (off == 0)
            b = row.name0;
         else if (off >= SIZE_AT && off < SIZE_AT + SIZE_LEN)
            b = row.size_txt[8*(SIZE_AT+SIZE_LEN-1-off) +: 8];
         else if (off == TYPE_AT)
            b = row.type_ch;
         if (off == BLOCK_BYTES - 1) begin
            typed_hdr  = row.typed;
            typed_size = row.t_size;
            typed_type = row.t_type;
            typed_sum  = row.t_sum;
         end
         send_byte(b);
         typed_hdr = 1'b0;
      end
      while (stage == PH_BODY || stage == PH_PAD)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      entry_row    row;
      int          mark;
      int          n_rand;
      int unsigned sz;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) emit_entry(dir_rows[i]);

      mark   = bytes_sent;
      n_rand = 0;
      while (bytes_sent - mark < RAND_BYTES || n_rand < 6) begin
         calm = (n_rand == 2 || n_rand == 3);
         if (n_rand == 4) begin
            req_chan.valid <= 1'b0;
            do @(negedge clock); while (deframed_q.size() != 0);
         end
         row = '{8'($urandom_range(1, 255)), '0, '0, FILL_RAND, 1'b0, '0, '0, '0};
         if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 9))
               0:       sz = 0;
               1:       sz = 512 * $urandom_range(1, 3);
               2, 3:    sz = $urandom_range(513, 3000);
               default: sz = $urandom_range(1, 511);
            endcase
            row.size_txt = octal_text(sz);
            if ($urandom_range(0, 9) < 7)
               row.type_ch = CHAR_ZERO + 8'($urandom_range(0, 7));
            else
               row.type_ch = non_octal();
         end else begin
            row.size_txt = {$urandom, $urandom, $urandom};
            row.type_ch  = 8'($urandom_range(0, 255));
         end
         emit_entry(row);
         n_rand++;
      end
      calm = 1'b0;

      row = '{8'h00, "000000000144", "5", FILL_RAND, 1'b0, '0, '0, '0};
      emit_entry(row);
      send_byte(8'h00);
      send_byte(8'hFF);
      repeat (150) send_byte(8'($urandom_range(0, 255)));

      req_chan.valid <= 1'b0;
      do @(negedge clock); while (deframed_q.size() != 0);
      repeat (20) @(negedge clock);
      if (bad_fields == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tsd_pkg.sv
sv/tsd_ifs.sv
sv/tsd_core.sv
sv/tsd_out_reg.sv
sv/tar_stream_deframer.sv
dv/tb_top.sv
